// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and controller/datapath interface types for the
// sliding window mode filter
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int VALUE_BITS = 8;
  localparam int NUM_VALUES = 1 << VALUE_BITS;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = FILL_W;

  localparam int SAMPLE_W = 8;
  localparam int MODE_W   = 8;
  localparam int CFG_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-1:0] REG_WINDOW_SIZE = ADDR_W'(0);
  localparam logic [CFG_W-1:0]  WINDOW_SIZE_RST = CFG_W'(1);

  // one-hot style commands from the controller
  typedef struct packed {
    logic load;      // capture transfer, apply start request
    logic ring_rd;   // read oldest ring entry
    logic drop_rd;   // read count of the leaving value
    logic drop_wr;   // decrement count, advance oldest pointer
    logic add_rd;    // write sample into ring, read its count
    logic add_wr;    // increment count, arm the scan
    logic scan_rd;   // read next count table entry
    logic emit;      // load result register
  } swm_cmd_t;

  typedef struct packed {
    logic drop_needed;
    logic fill_eq_k;
    logic scan_last;
    logic out_free;
  } swm_stat_t;

endpackage

// ===== hdl/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer for one sample: drop oldest entries, add the new one,
// scan the count table, once the window is full hand the result to the output register
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  swm_pkg::swm_stat_t stat,
  output swm_pkg::swm_cmd_t  cmd
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DROP_CHK,
    DROP_CNT,
    DROP_WR,
    ADD_WR,
    SCAN,
    SCAN_END,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DROP_CHK;
        end
      end
      DROP_CHK: begin
        if (stat.drop_needed) begin
          cmd.ring_rd = 1'b1;
          state_next  = DROP_CNT;
        end else begin
          cmd.add_rd = 1'b1;
          state_next = ADD_WR;
        end
      end
      DROP_CNT: begin
        cmd.drop_rd = 1'b1;
        state_next  = DROP_WR;
      end
      DROP_WR: begin
        cmd.drop_wr = 1'b1;
        state_next  = DROP_CHK;
      end
      ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = SCAN_END;
        end
      end
      SCAN_END: begin
        state_next = EMIT;
      end
      EMIT: begin
        priority if (!stat.fill_eq_k) begin
          state_next = IDLE;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end else begin
          state_next = EMIT;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

endmodule

// ===== hdl/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// sample ring, count table with per-entry valid bits, scan compare
// and output register
// ----------------------------------------------------------------------------
module swm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  swm_pkg::swm_cmd_t               cmd,
  output swm_pkg::swm_stat_t              stat,
  input  logic [swm_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            start_req,
  input  logic [swm_pkg::CFG_W-1:0]       window_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [swm_pkg::MODE_W-1:0]      mode_value
);
  import swm_pkg::*;

  // ring of the last samples, contents undefined until written
  logic [VALUE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [VALUE_BITS-1:0] ring_rd;

  // count table, entries without valid bit read as zero
  logic [CNT_W-1:0]      cnt_mem [NUM_VALUES];
  logic [NUM_VALUES-1:0] cnt_vld;
  logic [CNT_W-1:0]      cnt_rd;
  logic                  cnt_vld_rd;
  logic [CNT_W-1:0]      cnt_val;

  logic [VALUE_BITS-1:0] sample_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [FILL_W-1:0]     fill;
  logic [PTR_W-1:0]      optr;
  logic [PTR_W-1:0]      optr_next;
  logic [PTR_W:0]        wr_sum;
  logic [PTR_W-1:0]      wr_idx;
  logic [FILL_W-1:0]     k_eff;

  logic [VALUE_BITS-1:0] scan_idx;
  logic [VALUE_BITS-1:0] pipe_idx;
  logic                  pipe_vld;
  logic [CNT_W-1:0]      max_count;
  logic [VALUE_BITS-1:0] best;

  logic                  cnt_we;
  logic                  cnt_re;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [VALUE_BITS-1:0] cnt_raddr;

  // effective window length
  always_comb begin
    priority if (window_size == '0) begin
      k_eff = FILL_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      k_eff = FILL_W'(MAX_WINDOW);
    end else begin
      k_eff = FILL_W'(window_size);
    end
  end

  // ring index arithmetic
  assign wr_sum    = (PTR_W + 1)'(optr) + (PTR_W + 1)'(fill);
  assign wr_idx    = (int'(wr_sum) >= MAX_WINDOW) ?
                     PTR_W'(int'(wr_sum) - MAX_WINDOW) : PTR_W'(wr_sum);
  assign optr_next = (int'(optr) == MAX_WINDOW - 1) ? '0 : optr + PTR_W'(1);

  assign cnt_val   = cnt_vld_rd ? cnt_rd : '0;
  assign cnt_we    = (cmd.drop_wr && (cnt_val != '0)) || cmd.add_wr;
  assign cnt_wdata = cmd.add_wr ? cnt_val + CNT_W'(1) : cnt_val - CNT_W'(1);
  assign cnt_re    = cmd.drop_rd || cmd.add_rd || cmd.scan_rd;

  always_comb begin
    priority if (cmd.drop_rd) begin
      cnt_raddr = ring_rd;
    end else if (cmd.add_rd) begin
      cnt_raddr = sample_q;
    end else begin
      cnt_raddr = scan_idx;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.add_rd) begin
      ring_mem[wr_idx] <= sample_q;
    end
    if (cmd.ring_rd) begin
      ring_rd <= ring_mem[optr];
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[val_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld    <= '0;
      cnt_vld_rd <= 1'b0;
    end else begin
      if (cmd.load && start_req) begin
        cnt_vld <= '0;
      end else if (cnt_we) begin
        cnt_vld[val_q] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_vld_rd <= cnt_vld[cnt_raddr];
      end
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      optr <= '0;
    end else begin
      if (cmd.load && start_req) begin
        fill <= '0;
        optr <= '0;
      end else if (cmd.add_rd) begin
        fill <= fill + FILL_W'(1);
      end else if (cmd.drop_wr) begin
        fill <= fill - FILL_W'(1);
        optr <= optr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample[VALUE_BITS-1:0];
    end
    if (cmd.drop_rd) begin
      val_q <= ring_rd;
    end else if (cmd.add_rd) begin
      val_q <= sample_q;
    end
  end

  // count table scan, first strictly larger count wins
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      scan_idx  <= '0;
      max_count <= '0;
      best      <= '0;
    end else begin
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + VALUE_BITS'(1);
        pipe_idx <= scan_idx;
      end
      if (pipe_vld && (cnt_val > max_count)) begin
        max_count <= cnt_val;
        best      <= pipe_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mode_value <= MODE_W'(best);
    end
  end

  assign stat.drop_needed = (fill >= k_eff) && (fill != '0);
  assign stat.fill_eq_k   = (fill == k_eff);
  assign stat.scan_last   = (scan_idx == '1);
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

// ===== hdl/sliding_window_mode.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mode
// running mode filter over the last window_size samples (0 acts as 1, above 64 clamps to 64);
// one mode per sample once the window is full, ties to the smallest value
// ----------------------------------------------------------------------------
// in_stall stays high until the current sample is done, so a new sample is taken only in IDLE;
// the work per sample is dominated by the 256-entry count table scan,
//   one entry per cycle
// reset: synchronous, clears window, count table valid bits and window_size = 1
// the output register holds one result while the next sample is processed
// ----------------------------------------------------------------------------
module sliding_window_mode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          start_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swm_pkg::MODE_W-1:0]    mode_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::DATA_W-1:0]    pwdata,
  output logic [swm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import swm_pkg::*;

  logic [CFG_W-1:0] window_size;
  swm_cmd_t         cmd;
  swm_stat_t        stat;
  logic             reg_sel;

  // register index from the word address
  assign reg_sel = ({paddr[ADDR_W-1:2], 2'b00} == REG_WINDOW_SIZE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(window_size) : '0;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample      (sample),
    .start_req   (start_req),
    .window_size (window_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode_value  (mode_value)
  );

endmodule
